>>> hw/rtl/prr_pkg.sv
// ----------------------------------------------------------------------------
// prr_pkg
// Shared types, constants and helpers for the pyramid reduce block.
// ----------------------------------------------------------------------------
`default_nettype none

package prr_pkg;

    localparam int KSIZE         = 5;
    localparam int PIX_W         = 24;
    localparam int CH_W          = 8;
    localparam int NUM_CH        = 3;
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 12;
    localparam int CFG_W         = 13;
    localparam int WCFG_W        = 12;
    localparam int HCFG_W        = 13;
    localparam int HSUM_W        = 12;
    localparam int VSUM_W        = 16;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0]      t_pix;
    typedef t_pix [KSIZE-1:0]      t_col;
    typedef t_col [KSIZE-1:0]      t_win;
    typedef logic [2:0]            t_dist;

    // one-dimensional binomial weights 1,4,6,4,1
    function automatic logic [2:0] kw(input int k);
        logic [2:0] v;
        case (k)
            0: v = 3'd1;
            1: v = 3'd4;
            2: v = 3'd6;
            3: v = 3'd4;
            4: v = 3'd1;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    // distance back from the newest position to the mirrored tap position
    function automatic t_dist mirror_dist(input int last, input int pos,
                                          input int d, input int n);
        int o;
        o = pos + d;
        if (o < 0) o = -o;
        if (o >= n) o = 2 * n - 2 - o;
        if (o < 0) o = 0;
        if (o >= n) o = n - 1;
        return t_dist'(last - o);
    endfunction

    // (a - d) mod 5 for a, d in 0..4
    function automatic logic [2:0] sub_mod5(input logic [2:0] a, input t_dist d);
        logic [3:0] v;
        v = {1'b0, a} + 4'd5 - {1'b0, d};
        if (v >= 4'd5) v = v - 4'd5;
        return v[2:0];
    endfunction

    function automatic t_pix sel5(input t_col v, input t_dist k);
        t_pix p;
        case (k)
            3'd0: p = v[0];
            3'd1: p = v[1];
            3'd2: p = v[2];
            3'd3: p = v[3];
            3'd4: p = v[4];
            default: p = v[0];
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/prr_line_store.sv
// ----------------------------------------------------------------------------
// prr_line_store
// Five row banks; one write port and one registered read per bank.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_line_store
    import prr_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_wr_en,
    input  wire logic [2:0]                   i_wr_bank,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  wire t_pix                         i_wr_data,
    input  wire logic                         i_rd_en,
    output t_col                              o_rd_data
);

    t_pix r_rd [KSIZE];

    for (genvar b = 0; b < KSIZE; b++) begin : g_bank
        t_pix r_mem [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_bank == 3'(b))) begin
                r_mem[i_addr] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_rd[b] <= r_mem[i_addr];
            end
        end
    end

    always_comb begin
        for (int b = 0; b < KSIZE; b++) begin
            o_rd_data[b] = r_rd[b];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/prr_cell.sv
// ----------------------------------------------------------------------------
// prr_cell
// One column of the 5x5 window; takes the upstream column on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_cell
    import prr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_shift,
    input  wire t_col i_col,
    output t_col      o_col
);

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

>>> hw/rtl/pyramid_reduce_rgb_core.sv
// ----------------------------------------------------------------------------
// pyramid_reduce_rgb_core
// 5x5 binomial blur with 2:1 decimation on a raster RGB stream.
// ----------------------------------------------------------------------------
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------
// pixel in  | i_valid / o_ready    | i_pix_red, i_pix_green, i_pix_blue
// result    | o_valid / i_ready    | o_out_red/green/blue, o_end_of_line/frame
// config    | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One pixel per clock while the skid register is empty; each bank gives one read.
// o_valid rises once the pixel that completes a window passes stages 1 to 4 and the output register.
// Reset is synchronous; it clears counters and valid bits and loads 640x480.
// A result blocked at the output drops into a skid register; while the skid
// is full the whole pipeline holds and o_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module pyramid_reduce_rgb_core
    import prr_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // config port
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    // pixel input
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [CH_W-1:0]   i_pix_red,
    input  wire logic [CH_W-1:0]   i_pix_green,
    input  wire logic [CH_W-1:0]   i_pix_blue,
    // result output
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [CH_W-1:0]        o_out_red,
    output logic [CH_W-1:0]        o_out_green,
    output logic [CH_W-1:0]        o_out_blue,
    output logic                   o_end_of_line,
    output logic                   o_end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);

    // ---------------- configuration ----------------
    logic [WCFG_W-1:0] r_image_width;
    logic [HCFG_W-1:0] r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WCFG_W'(RESET_WIDTH);
            r_image_height <= HCFG_W'(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_image_width  <= i_cfg_data[WCFG_W-1:0];
                REG_HEIGHT: r_image_height <= i_cfg_data[HCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic r_sk_v;
    logic adv;
    logic acc;

    // hold everything only when both output slots are full
    assign adv     = !r_sk_v;
    assign o_ready = adv;
    assign acc     = i_valid && adv;

    // ---------------- stage 0: position, triggers, mirror taps ----------------
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [2:0]       r_rmod;

    logic             s0_hit, s0_eol, s0_eof, s0_wrap, s0_last_row;
    t_dist            s0_cd [KSIZE];
    t_dist            s0_rd [KSIZE];
    t_pix             s0_px;

    assign s0_px = {i_pix_blue, i_pix_green, i_pix_red};

    always_comb begin
        int wi, hi, ci, ri, cpos, rpos;
        logic col_hit, row_hit;
        wi = (r_image_width == '0) ? 1 :
             ((int'(r_image_width) > MAX_WIDTH) ? MAX_WIDTH : int'(r_image_width));
        hi = (r_image_height == '0) ? 1 :
             ((int'(r_image_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(r_image_height));
        ci = int'(r_col);
        ri = int'(r_row);
        col_hit = (ci < wi) && ((!r_col[0] && ci >= 2) || (r_col[0] && ci == wi - 1));
        row_hit = (ri < hi) && ((!r_row[0] && ri >= 2) || (r_row[0] && ri == hi - 1));
        cpos = r_col[0] ? ci - 1 : ci - 2;
        rpos = r_row[0] ? ri - 1 : ri - 2;
        for (int k = 0; k < KSIZE; k++) begin
            s0_cd[k] = mirror_dist(ci, cpos, k - 2, wi);
            s0_rd[k] = mirror_dist(ri, rpos, k - 2, hi);
        end
        s0_hit      = col_hit && row_hit;
        s0_eol      = (cpos == ((wi & ~1) - 2));
        s0_eof      = s0_eol && (rpos == ((hi & ~1) - 2));
        s0_wrap     = (ci + 1 >= wi);
        s0_last_row = (ri + 1 >= hi);
    end

    // advance raster position on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_rmod <= '0;
        end else if (acc) begin
            if (s0_wrap) begin
                r_col <= '0;
                if (s0_last_row) begin
                    r_row  <= '0;
                    r_rmod <= '0;
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_rmod <= (r_rmod == 3'(KSIZE - 1)) ? 3'd0 : r_rmod + 3'd1;
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ---------------- line store ----------------
    t_col ls_rd;

    prr_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (acc),
        .i_wr_bank (r_rmod),
        .i_addr    (r_col),
        .i_wr_data (s0_px),
        .i_rd_en   (acc),
        .o_rd_data (ls_rd)
    );

    // ---------------- stage 1: column by row distance ----------------
    logic  r1_v, r1_hit, r1_eol, r1_eof;
    t_pix  r1_px;
    logic [2:0] r1_rmod;
    t_dist r1_cd [KSIZE];
    t_dist r1_rd [KSIZE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_px   <= s0_px;
            r1_rmod <= r_rmod;
            r1_hit  <= s0_hit;
            r1_eol  <= s0_eol;
            r1_eof  <= s0_eof;
            r1_cd   <= s0_cd;
            r1_rd   <= s0_rd;
        end
    end

    t_col s1_col;

    // distance 0 is the current row: take the incoming pixel, not the old bank
    always_comb begin
        s1_col[0] = r1_px;
        for (int d = 1; d < KSIZE; d++) begin
            s1_col[d] = sel5(ls_rd, sub_mod5(r1_rmod, t_dist'(d)));
        end
    end

    // ---------------- column cells ----------------
    logic shift;
    t_col cell_out [KSIZE];

    assign shift = adv && r1_v;

    for (genvar k = 0; k < KSIZE; k++) begin : g_cell
        if (k == 0) begin : g_head
            prr_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_col   (s1_col),
                .o_col   (cell_out[k])
            );
        end else begin : g_body
            prr_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_col   (cell_out[k-1]),
                .o_col   (cell_out[k])
            );
        end
    end

    // ---------------- stage 2: pick the mirrored window ----------------
    logic  r2_v, r2_eol, r2_eof;
    t_dist r2_cd [KSIZE];
    t_dist r2_rd [KSIZE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v && r1_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_eol <= r1_eol;
            r2_eof <= r1_eof;
            r2_cd  <= r1_cd;
            r2_rd  <= r1_rd;
        end
    end

    t_win s2_win;

    always_comb begin
        t_col colsel;
        for (int j = 0; j < KSIZE; j++) begin
            case (r2_cd[j])
                3'd0: colsel = cell_out[0];
                3'd1: colsel = cell_out[1];
                3'd2: colsel = cell_out[2];
                3'd3: colsel = cell_out[3];
                3'd4: colsel = cell_out[4];
                default: colsel = cell_out[0];
            endcase
            for (int i = 0; i < KSIZE; i++) begin
                s2_win[i][j] = sel5(colsel, r2_rd[i]);
            end
        end
    end

    // ---------------- stage 3: horizontal sums per row ----------------
    logic r3_v, r3_eol, r3_eof;
    t_win r3_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_win <= s2_win;
            r3_eol <= r2_eol;
            r3_eof <= r2_eof;
        end
    end

    logic [HSUM_W-1:0] s3_hsum [KSIZE][NUM_CH];

    always_comb begin
        logic [HSUM_W-1:0] acc_h;
        for (int i = 0; i < KSIZE; i++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                acc_h = '0;
                for (int j = 0; j < KSIZE; j++) begin
                    acc_h = acc_h + HSUM_W'(kw(j)) * HSUM_W'(r3_win[i][j][CH_W*ch +: CH_W]);
                end
                s3_hsum[i][ch] = acc_h;
            end
        end
    end

    // ---------------- stage 4: vertical sum and scale ----------------
    logic r4_v, r4_eol, r4_eof;
    logic [HSUM_W-1:0] r4_hsum [KSIZE][NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_hsum <= s3_hsum;
            r4_eol  <= r3_eol;
            r4_eof  <= r3_eof;
        end
    end

    logic [CH_W-1:0] s4_res [NUM_CH];

    always_comb begin
        logic [VSUM_W-1:0] acc_v;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            acc_v = '0;
            for (int i = 0; i < KSIZE; i++) begin
                acc_v = acc_v + VSUM_W'(kw(i)) * VSUM_W'(r4_hsum[i][ch]);
            end
            // divide by 256, truncate
            s4_res[ch] = acc_v[VSUM_W-1 -: CH_W];
        end
    end

    // ---------------- output register and skid ----------------
    logic            r_ov;
    logic [CH_W-1:0] r_o_res [NUM_CH];
    logic            r_o_eol, r_o_eof;
    logic [CH_W-1:0] r_sk_res [NUM_CH];
    logic            r_sk_eol, r_sk_eof;
    logic            new_res, to_out, to_skid, from_skid;

    assign new_res   = adv && r4_v;
    assign to_out    = new_res && (!r_ov || i_ready);
    assign to_skid   = new_res && r_ov && !i_ready;
    assign from_skid = r_sk_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_sk_v <= 1'b0;
        end else begin
            if (from_skid) begin
                r_sk_v <= 1'b0;
            end else if (to_skid) begin
                r_sk_v <= 1'b1;
            end
            if (to_out || to_skid || from_skid) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (from_skid) begin
            r_o_res <= r_sk_res;
            r_o_eol <= r_sk_eol;
            r_o_eof <= r_sk_eof;
        end else if (to_out) begin
            r_o_res <= s4_res;
            r_o_eol <= r4_eol;
            r_o_eof <= r4_eof;
        end
        if (to_skid) begin
            r_sk_res <= s4_res;
            r_sk_eol <= r4_eol;
            r_sk_eof <= r4_eof;
        end
    end

    assign o_valid        = r_ov;
    assign o_out_red      = r_o_res[0];
    assign o_out_green    = r_o_res[1];
    assign o_out_blue     = r_o_res[2];
    assign o_end_of_line  = r_o_eol;
    assign o_end_of_frame = r_o_eof;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pyramid_reduce_rgb_core. Whole frames of RGB pixels
// go in under several image sizes and handshake pressure levels; a scoreboard
// predicts every reduced pixel and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import prr_pkg::*;

    localparam int STORE_COLS = 2048;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 12;

    // sender / receiver behavior modes
    typedef enum int {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} t_flow;

    // pixel patterns for a frame
    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_ALT} t_fill;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       eol;
        logic       eof;
    } t_reduced;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_ready;
    logic [7:0]       i_pix_red;
    logic [7:0]       i_pix_green;
    logic [7:0]       i_pix_blue;
    logic             o_valid;
    logic             i_ready;
    logic [7:0]       o_out_red;
    logic [7:0]       o_out_green;
    logic [7:0]       o_out_blue;
    logic             o_end_of_line;
    logic             o_end_of_frame;

    t_flow flow;
    int    hold_off;
    int    pixels_sent;
    int    results_seen;

    // ------------------------------------------------------------------------
    // Scoreboard: owns a model of the line store and counters, predicts the
    // reduced pixel for each accepted source pixel and queues it.
    // ------------------------------------------------------------------------
    class reduce_scoreboard;
        bit [23:0] rows[0:KSIZE*STORE_COLS-1];
        int        col_pos;
        int        row_pos;
        bit [11:0] width_reg;
        bit [12:0] height_reg;
        t_reduced  pending[$];
        int        errors;

        function new();
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = 12'(RESET_WIDTH);
            height_reg = 13'(RESET_HEIGHT);
            errors     = 0;
        endfunction

        function void set_reg(logic idx, int value);
            if (idx == REG_WIDTH) width_reg = 12'(value);
            else height_reg = 13'(value);
        endfunction

        function int eff_width();
            if (width_reg == 0) return 1;
            return (width_reg > STORE_COLS) ? STORE_COLS : int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg == 0) return 1;
            return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        endfunction

        function int reflect(int p, int d, int n);
            int o;
            o = p + d;
            if (o < 0) o = -o;
            if (o >= n) o = 2 * n - 2 - o;
            if (o < 0) o = 0;
            if (o >= n) o = n - 1;
            return o;
        endfunction

        // even output position that becomes complete at source position last
        function bit completes(int last, int n, output int pos);
            int lim, p, need;
            pos = 0;
            if (n < 2) return 0;
            lim = 2 * (n / 2) - 2;
            for (int k = 2; k >= 1; k--) begin
                if (last < k) continue;
                p = last - k;
                if (p[0] || p > lim) continue;
                need = (p + 2 < n - 1) ? p + 2 : n - 1;
                if (need == last) begin
                    pos = p;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int        w, h, orow, ocol, sr, sc, wt;
            int        wk[5];
            int        acc[3];
            bit [23:0] v;
            t_reduced  res;
            wk = '{1, 4, 6, 4, 1};
            w  = eff_width();
            h  = eff_height();
            if (col_pos < STORE_COLS)
                rows[(row_pos % KSIZE) * STORE_COLS + col_pos] = {b, g, r};
            if (col_pos < w && row_pos < h && completes(row_pos, h, orow)
                    && completes(col_pos, w, ocol)) begin
                acc = '{0, 0, 0};
                for (int i = 0; i < 5; i++) begin
                    sr = reflect(orow, i - 2, h);
                    for (int j = 0; j < 5; j++) begin
                        sc = reflect(ocol, j - 2, w);
                        v  = rows[(sr % KSIZE) * STORE_COLS + sc];
                        wt = wk[i] * wk[j];
                        acc[0] += wt * v[7:0];
                        acc[1] += wt * v[15:8];
                        acc[2] += wt * v[23:16];
                    end
                end
                res.red   = 8'(acc[0] >> 8);
                res.green = 8'(acc[1] >> 8);
                res.blue  = 8'(acc[2] >> 8);
                res.eol   = (ocol == 2 * (w / 2) - 2);
                res.eof   = res.eol && (orow == 2 * (h / 2) - 2);
                pending = {pending, res};
            end
            if (col_pos + 1 >= w) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
            end else begin
                col_pos = col_pos + 1;
            end
        endfunction

        task report(string what);
            $display("mismatch @%0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(t_reduced got);
            t_reduced exp;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            exp = pending.pop_front();
            if (got.red !== exp.red)
                report($sformatf("red %0d, want %0d", got.red, exp.red));
            if (got.green !== exp.green)
                report($sformatf("green %0d, want %0d", got.green, exp.green));
            if (got.blue !== exp.blue)
                report($sformatf("blue %0d, want %0d", got.blue, exp.blue));
            if (got.eol !== exp.eol)
                report($sformatf("end_of_line %b, want %b", got.eol, exp.eol));
            if (got.eof !== exp.eof)
                report($sformatf("end_of_frame %b, want %b", got.eof, exp.eof));
        endtask
    endclass

    reduce_scoreboard sb;

    pyramid_reduce_rgb_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pix_red      (i_pix_red),
        .i_pix_green    (i_pix_green),
        .i_pix_blue     (i_pix_blue),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: decide ready at each falling edge. A pending hold-off wins
    // over the random stall so the block fills up and must stall its input.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                i_ready <= 1'b0;
            end else if (flow == FLOW_RECV_STALL) begin
                i_ready <= ($urandom_range(99) >= 77);
            end else if (flow == FLOW_BOTH) begin
                i_ready <= ($urandom_range(99) >= 33);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor: note accepted pixels, check accepted results, run watchdog.
    int quiet_cycles;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_pixel(i_pix_red, i_pix_green, i_pix_blue);
            if (o_valid && i_ready) begin
                sb.check_result('{o_out_red, o_out_green, o_out_blue,
                                  o_end_of_line, o_end_of_frame});
                results_seen++;
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Hold config data only for one cycle; the block is idle whenever called.
    task write_reg(logic idx, int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Offer one pixel; hold it until the transaction completes.
    task push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap_pct;
        gap_pct = (flow == FLOW_SEND_IDLE) ? 77 : (flow == FLOW_BOTH) ? 33 : 0;
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_pix_red   <= r;
        i_pix_green <= g;
        i_pix_blue  <= b;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    task push_pixels(int count, t_fill kind);
        logic [7:0] r, g, b;
        for (int n = 0; n < count; n++) begin
            case (kind)
                FILL_ONES:  {r, g, b} = '1;
                FILL_ZEROS: {r, g, b} = '0;
                FILL_ALT:   {r, g, b} = n[0] ? 24'h55aa55 : 24'haa55aa;
                default: begin
                    r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
                    if ($urandom_range(9) == 0) r = $urandom_range(1) ? 8'hff : 8'h00;
                end
            endcase
            push_pixel(r, g, b);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Wait until every predicted result is out, then let the pipeline settle.
    task drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task run_frame(int w, int h, t_fill kind);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        push_pixels(sb.eff_width() * sb.eff_height(), kind);
        drain();
    endtask

    int w, h, frames;

    initial begin
        sb           = new();
        flow         = FLOW_FREE;
        hold_off     = 0;
        pixels_sent  = 0;
        results_seen = 0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_WIDTH;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_pix_red    = '0;
        i_pix_green  = '0;
        i_pix_blue   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: smallest sizes, extreme pixel values, degenerate sizes
        run_frame(2, 2, FILL_ONES);
        run_frame(2, 2, FILL_ZEROS);
        run_frame(3, 3, FILL_ALT);
        run_frame(5, 4, FILL_RANDOM);
        run_frame(1, 3, FILL_RANDOM);     // single column: no results
        run_frame(0, 0, FILL_RANDOM);     // zero acts as one
        run_frame(4, 1, FILL_RANDOM);     // single row: no results
        run_frame(3, 2, FILL_RANDOM);     // trailing odd column dropped

        // size change mid frame: rewrite sizes with the counters in row 3
        run_frame(8, 8, FILL_RANDOM);
        write_reg(REG_WIDTH, 8);
        write_reg(REG_HEIGHT, 8);
        push_pixels(24, FILL_RANDOM);
        drain();
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 6);
        push_pixels(12, FILL_RANDOM);
        drain();

        // register extremes: a few pixels under over-range sizes, then a
        // shrink that leaves the column counter past the new width
        write_reg(REG_WIDTH, 4095);
        write_reg(REG_HEIGHT, 8191);
        push_pixels(6, FILL_RANDOM);
        drain();
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 4);
        push_pixels(13, FILL_RANDOM);
        drain();

        // long receiver hold-off while the sender keeps offering
        flow     = FLOW_FREE;
        hold_off = 400;
        run_frame(16, 8, FILL_RANDOM);

        // random frames, one phase per handshake mode
        frames = 0;
        for (int ph = 0; ph < 4; ph++) begin
            flow = t_flow'(ph);
            repeat (3) begin
                if ($urandom_range(7) == 0) begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(1, 3);
                end else begin
                    w = $urandom_range(2, 8);
                    h = $urandom_range(2, 6);
                end
                run_frame(w, h, FILL_RANDOM);
                frames++;
            end
        end

        flow = FLOW_FREE;
        drain();
        $display("covered %0d source pixels, %0d reduced pixels, %0d random frames",
                 pixels_sent, results_seen, frames);
        $display("odd, degenerate and over-range sizes, mid-frame resizes, "
                 , "a long output stall and four flow modes");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
